// ===== sv/cupp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cupp_pkg
// Types and constants shared by the cell update packet parser modules.
// ----------------------------------------------------------------------------
package cupp_pkg;

  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 128;

  typedef enum logic [3:0] {
    PH_HEADER = 4'd0,
    PH_OWNER  = 4'd1,
    PH_CELL   = 4'd2,
    PH_XPOS   = 4'd3,
    PH_YPOS   = 4'd4,
    PH_SIZE   = 4'd5,
    PH_FLAGS  = 4'd6,
    PH_DCOUNT = 4'd7,
    PH_DID    = 4'd8,
    PH_ECOUNT = 4'd9,
    PH_EPREY  = 4'd10,
    PH_EEATER = 4'd11,
    PH_IDLE   = 4'd15
  } phase_t;

  typedef enum logic [1:0] {
    KIND_UPDATE  = 2'd0,
    KIND_DESTROY = 2'd1,
    KIND_EAT     = 2'd2,
    KIND_END     = 2'd3
  } kind_t;

  localparam logic [4:0] HDR_TYPE_OWNER = 5'h01;
  localparam logic [3:0] HDR_TYPE_FORCE = 4'h4;
  localparam logic [7:0] FLAG_LIMIT     = 8'h0f;

  typedef struct packed {
    kind_t              kind;
    logic [7:0]         header;
    logic [15:0]        owner;
    logic [15:0]        cell_id;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [15:0]        size;
    logic [7:0]         flags;
    logic signed [31:0] order_tag;
    logic               eop;
  } rec_t;

endpackage

// ===== sv/cupp_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cupp_parser
// Parse state and field assembly; decodes one packet byte per step.
// ----------------------------------------------------------------------------
module cupp_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic [7:0]         data_byte,
  input  logic               packet_start,
  input  logic signed [31:0] order_tag_in,
  output logic               emit,
  output cupp_pkg::rec_t     rec
);

  cupp_pkg::phase_t   phase_r, phase_nxt;
  logic               pend_v_r, pend_v_nxt;
  logic [7:0]         pend_b_r, pend_b_nxt;
  logic [7:0]         hdr_r, hdr_nxt;
  logic [15:0]        owner_r, owner_nxt;
  logic [15:0]        cell_r, cell_nxt;
  logic [15:0]        x_r, x_nxt;
  logic [15:0]        y_r, y_nxt;
  logic [15:0]        size_r, size_nxt;
  logic [7:0]         flags_r, flags_nxt;
  logic [15:0]        left_r, left_nxt;
  logic signed [31:0] tag_r, tag_nxt;

  cupp_pkg::phase_t   ph;
  logic               full;
  logic [15:0]        word;
  logic [15:0]        left_dec;
  cupp_pkg::phase_t   after;

  // Next present update field; PH_HEADER means the record is complete.
  function automatic cupp_pkg::phase_t next_field(input cupp_pkg::phase_t done,
                                                  input logic [7:0] hdr);
    cupp_pkg::phase_t p;
    p = cupp_pkg::PH_HEADER;
    if (hdr[7]) begin
      p = cupp_pkg::PH_FLAGS;
    end
    if (!hdr[6] && done != cupp_pkg::PH_SIZE) begin
      p = cupp_pkg::PH_SIZE;
    end
    if (done == cupp_pkg::PH_XPOS) begin
      p = cupp_pkg::PH_YPOS;
    end else if (done == cupp_pkg::PH_CELL && !hdr[5]) begin
      p = cupp_pkg::PH_XPOS;
    end
    if (done == cupp_pkg::PH_FLAGS) begin
      p = cupp_pkg::PH_HEADER;
    end
    return p;
  endfunction

  always_comb begin
    phase_nxt  = phase_r;
    pend_v_nxt = pend_v_r;
    pend_b_nxt = pend_b_r;
    hdr_nxt    = hdr_r;
    owner_nxt  = owner_r;
    cell_nxt   = cell_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    size_nxt   = size_r;
    flags_nxt  = flags_r;
    left_nxt   = left_r;
    tag_nxt    = tag_r;
    emit       = 1'b0;
    rec        = '0;
    after      = cupp_pkg::PH_HEADER;

    // A start byte restarts the packet and drops any half-collected value.
    ph   = packet_start ? cupp_pkg::PH_HEADER : phase_r;
    full = packet_start ? 1'b0 : pend_v_r;
    if (packet_start) begin
      tag_nxt    = order_tag_in;
      pend_v_nxt = 1'b0;
    end
    word     = {pend_b_r, data_byte};
    left_dec = left_r - 16'd1;

    case (ph)
      cupp_pkg::PH_HEADER: begin
        if (data_byte == 8'd0) begin
          phase_nxt = cupp_pkg::PH_DCOUNT;
        end else begin
          hdr_nxt   = data_byte;
          owner_nxt = '0;
          cell_nxt  = '0;
          x_nxt     = '0;
          y_nxt     = '0;
          size_nxt  = '0;
          flags_nxt = '0;
          phase_nxt = (data_byte[4:0] == cupp_pkg::HDR_TYPE_OWNER) ?
                      cupp_pkg::PH_OWNER : cupp_pkg::PH_CELL;
        end
      end
      cupp_pkg::PH_OWNER: begin
        pend_v_nxt = !full;
        pend_b_nxt = data_byte;
        if (full) begin
          owner_nxt = word;
          phase_nxt = cupp_pkg::PH_CELL;
        end
      end
      cupp_pkg::PH_CELL, cupp_pkg::PH_XPOS, cupp_pkg::PH_YPOS, cupp_pkg::PH_SIZE,
      cupp_pkg::PH_FLAGS: begin
        if (ph == cupp_pkg::PH_FLAGS) begin
          flags_nxt = data_byte;
        end else begin
          pend_v_nxt = !full;
          pend_b_nxt = data_byte;
          if (ph == cupp_pkg::PH_CELL) begin
            cell_nxt = full ? word : cell_r;
          end else if (ph == cupp_pkg::PH_XPOS) begin
            x_nxt = full ? word : x_r;
          end else if (ph == cupp_pkg::PH_YPOS) begin
            y_nxt = full ? word : y_r;
          end else begin
            size_nxt = full ? word : size_r;
          end
        end
        if (full || ph == cupp_pkg::PH_FLAGS) begin
          after     = next_field(ph, hdr_r);
          phase_nxt = after;
          if (after == cupp_pkg::PH_HEADER) begin
            emit          = 1'b1;
            rec.kind      = cupp_pkg::KIND_UPDATE;
            rec.header    = hdr_r;
            rec.owner     = owner_nxt;
            rec.cell_id   = cell_nxt;
            rec.pos_x     = x_nxt;
            rec.pos_y     = y_nxt;
            rec.size      = size_nxt;
            rec.flags     = flags_nxt;
            if (hdr_r[3:0] == cupp_pkg::HDR_TYPE_FORCE ||
                flags_nxt > cupp_pkg::FLAG_LIMIT) begin
              rec.flags[0] = 1'b1;
            end
          end
        end
      end
      cupp_pkg::PH_DCOUNT: begin
        pend_v_nxt = !full;
        pend_b_nxt = data_byte;
        if (full) begin
          left_nxt  = word;
          phase_nxt = (word == 16'd0) ? cupp_pkg::PH_ECOUNT : cupp_pkg::PH_DID;
        end
      end
      cupp_pkg::PH_DID: begin
        pend_v_nxt = !full;
        pend_b_nxt = data_byte;
        if (full) begin
          emit        = 1'b1;
          rec.kind    = cupp_pkg::KIND_DESTROY;
          rec.cell_id = word;
          left_nxt    = left_dec;
          if (left_dec == 16'd0) begin
            phase_nxt = cupp_pkg::PH_ECOUNT;
          end
        end
      end
      cupp_pkg::PH_ECOUNT: begin
        pend_v_nxt = !full;
        pend_b_nxt = data_byte;
        if (full) begin
          if (word == 16'd0) begin
            emit      = 1'b1;
            rec.kind  = cupp_pkg::KIND_END;
            rec.eop   = 1'b1;
            phase_nxt = cupp_pkg::PH_IDLE;
          end else begin
            left_nxt  = word;
            phase_nxt = cupp_pkg::PH_EPREY;
          end
        end
      end
      cupp_pkg::PH_EPREY: begin
        pend_v_nxt = !full;
        pend_b_nxt = data_byte;
        if (full) begin
          cell_nxt  = word;
          phase_nxt = cupp_pkg::PH_EEATER;
        end
      end
      cupp_pkg::PH_EEATER: begin
        pend_v_nxt = !full;
        pend_b_nxt = data_byte;
        if (full) begin
          emit        = 1'b1;
          left_nxt    = left_dec;
          rec.kind    = cupp_pkg::KIND_EAT;
          rec.owner   = word;
          rec.cell_id = cell_r;
          rec.eop     = (left_dec == 16'd0);
          phase_nxt   = (left_dec == 16'd0) ? cupp_pkg::PH_IDLE : cupp_pkg::PH_EPREY;
        end
      end
      default: begin
        phase_nxt = cupp_pkg::PH_IDLE;
      end
    endcase

    rec.order_tag = tag_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= cupp_pkg::PH_IDLE;
      pend_v_r <= 1'b0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      pend_v_r <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      pend_b_r <= pend_b_nxt;
      hdr_r    <= hdr_nxt;
      owner_r  <= owner_nxt;
      cell_r   <= cell_nxt;
      x_r      <= x_nxt;
      y_r      <= y_nxt;
      size_r   <= size_nxt;
      flags_r  <= flags_nxt;
      left_r   <= left_nxt;
      tag_r    <= tag_nxt;
    end
  end

endmodule

// ===== sv/cell_update_packet_parser_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cell_update_packet_parser_unit
// Byte-stream parser for cell update packets: update, destroy and eat records.
// ----------------------------------------------------------------------------
// Registers: a record's last byte word passes the input register, then the record
// is written to the result register (one input register, one result register).
// Throughput: one byte word per cycle, sustained, while the output is drained.
// Reset: synchronous active-low rst_n empties both registers and puts the
// parser in its idle phase, where bytes are dropped until a packet start.
module cell_update_packet_parser_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input words.
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [7:0] data_byte, [39:8] order_tag_in
  input  logic [cupp_pkg::IN_DATA_W-1:0]      in_tdata,
  // [0] packet_start
  input  logic                                in_tuser,
  // Result words.
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [7:0] header_byte, [23:8] owner_id, [39:24] cell_id, [55:40] pos_x,
  // [71:56] pos_y, [87:72] cell_size, [95:88] flag_bits, [127:96] order_tag
  output logic [cupp_pkg::OUT_DATA_W-1:0]     out_tdata,
  // [1:0] record_kind
  output logic [1:0]                          out_tuser,
  // end_of_packet
  output logic                                out_tlast
);

  // Input register stage. A byte word lands here and is decoded from this register
  // against the parser state.
  logic               s1_valid_r;
  logic [7:0]         s1_byte_r;
  logic               s1_start_r;
  logic signed [31:0] s1_tag_r;

  // Result register.
  logic               out_valid_r;
  cupp_pkg::rec_t     out_rec_r;

  logic               emit;
  cupp_pkg::rec_t     rec;
  logic               out_free;
  logic               consume;

  // The result register is free when empty or being read this cycle. A byte
  // that produces no record never waits for it, so only emitting bytes stall.
  assign out_free  = !out_valid_r || out_tready;
  assign consume   = s1_valid_r && (!emit || out_free);
  assign in_tready = !s1_valid_r || consume;

  cupp_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (consume),
    .data_byte    (s1_byte_r),
    .packet_start (s1_start_r),
    .order_tag_in (s1_tag_r),
    .emit         (emit),
    .rec          (rec)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (consume && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r  <= in_tdata[7:0];
      s1_start_r <= in_tuser;
      s1_tag_r   <= in_tdata[39:8];
    end
    if (consume && emit) begin
      out_rec_r <= rec;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_rec_r.kind;
  assign out_tlast  = out_rec_r.eop;
  assign out_tdata  = {out_rec_r.order_tag, out_rec_r.flags, out_rec_r.size,
                       out_rec_r.pos_y, out_rec_r.pos_x, out_rec_r.cell_id,
                       out_rec_r.owner, out_rec_r.header};

endmodule
